[src/tsp_pkg.sv]
// Shared types and constants for the trapezoid speed profile block.
// No dependencies; used by the controller, datapath, divider and top level.
`timescale 1ns / 1ps

package tsp_pkg;

   // Field and state widths
   localparam int POS_W     = 16;              // encoder and distance width
   localparam int SPEED_W   = 24;              // Q16.8 speed, saturating
   localparam int GAIN_W    = 21;              // max_speed * 10, signed
   localparam int DIV_BITS  = 19;              // quotient magnitude bits
   localparam int DIVISOR_W = POS_W + 1;       // limit + 1, up to 65536
   localparam int PCT_W     = 8;
   localparam int MAG_W     = 7;
   localparam int DUTY_W    = 10;
   localparam int ADDR_W    = 4;
   localparam int DATA_W    = 32;

   // Profile constants
   localparam int STEP_GAIN = 10;
   localparam int PCT_MAX   = 100;
   localparam int CREEP_Q88 = 2560;

   // Register indexes (byte address = 4 * index)
   typedef enum logic [1:0] {
      REG_TOTAL = 2'd0,
      REG_ACCEL = 2'd1,
      REG_DECEL = 2'd2,
      REG_MAX   = 2'd3
   } reg_index_type;

   // Where the current tick falls within the move
   typedef enum logic [1:0] {
      ZONE_UP     = 2'd0,
      ZONE_CRUISE = 2'd1,
      ZONE_DECEL  = 2'd2,
      ZONE_DONE   = 2'd3
   } zone_type;

   typedef struct packed {
      logic [POS_W-1:0]        total_distance;
      logic [POS_W-1:0]        accel_distance;
      logic [POS_W-1:0]        decel_distance;
      logic signed [POS_W-1:0] max_speed;
   } cfg_type;

   // Controller to datapath
   typedef struct packed {
      logic latch_enc;     // capture the request's encoder count
      logic start_move;    // latch start position and ramp limits
      logic div_go;        // launch a speed step division
      logic div_down;      // division is for the ramp-down step
      logic write_up;      // take the ramp-up step and seed the speed
      logic eval;          // classify the tick and stage the result
      logic apply;         // update speed or end the move in non-decel zones
      logic write_down;    // take the ramp-down step and update speed
      logic load_rsp;      // move the staged result to the output
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic     awaiting;
      logic     div_done;
      zone_type zone;
   } status_type;

endpackage

[src/tsp_divider.sv]
// Radix-2 restoring divider for the speed step: signed quotient, truncated
// toward zero, one quotient bit per cycle. Depends on tsp_pkg.
`timescale 1ns / 1ps

module tsp_divider (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  go,
   input  logic [tsp_pkg::DIV_BITS-1:0]          dividend_mag,
   input  logic                                  negate,
   input  logic [tsp_pkg::DIVISOR_W-1:0]         divisor,
   output logic                                  done,
   output logic signed [tsp_pkg::SPEED_W-1:0]    quotient
);

   localparam int CNT_W = $clog2(tsp_pkg::DIV_BITS);
   localparam logic [CNT_W-1:0] LAST = CNT_W'(tsp_pkg::DIV_BITS - 1);

   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [CNT_W-1:0]                  count_ff, count_in;
   logic [tsp_pkg::DIV_BITS-1:0]      quo_ff, quo_in;
   logic [tsp_pkg::DIVISOR_W-1:0]     rem_ff, rem_in;
   logic [tsp_pkg::DIVISOR_W-1:0]     div_ff, div_in;
   logic                              neg_ff, neg_in;
   logic [tsp_pkg::DIVISOR_W:0]       trial;
   logic                              fits;
   logic [tsp_pkg::SPEED_W-1:0]       quo_ext;

   // One trial subtraction per cycle
   assign trial = {rem_ff, quo_ff[tsp_pkg::DIV_BITS-1]};
   assign fits  = (trial >= {1'b0, div_ff});

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      neg_in   = neg_ff;
      if (go) begin
         busy_in  = 1'b1;
         count_in = '0;
         quo_in   = dividend_mag;
         rem_in   = '0;
         div_in   = divisor;
         neg_in   = negate;
      end else if (busy_ff) begin
         quo_in   = {quo_ff[tsp_pkg::DIV_BITS-2:0], fits};
         rem_in   = fits ? tsp_pkg::DIVISOR_W'(trial - {1'b0, div_ff})
                         : tsp_pkg::DIVISOR_W'(trial);
         count_in = count_ff + CNT_W'(1);
         if (count_ff == LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff <= count_in;
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      div_ff   <= div_in;
      neg_ff   <= neg_in;
   end

   // Apply the sign of the dividend
   assign quo_ext  = {{(tsp_pkg::SPEED_W - tsp_pkg::DIV_BITS){1'b0}}, quo_ff};
   assign quotient = neg_ff ? -$signed(quo_ext) : $signed(quo_ext);
   assign done     = done_ff;

endmodule

[src/tsp_datapath.sv]
// Datapath of the speed profile: move state, speed update, zone compare,
// result staging and output registers. Depends on tsp_pkg and tsp_divider.
`timescale 1ns / 1ps

module tsp_datapath #(
   parameter int DUTY_FULL_SCALE = 1023
) (
   input  logic                                clock,
   input  logic                                reset,
   input  tsp_pkg::cmd_type                    cmd,
   output tsp_pkg::status_type                 status,
   input  tsp_pkg::cfg_type                    cfg,
   input  logic signed [tsp_pkg::POS_W-1:0]    req_encoder_count,
   output logic signed [tsp_pkg::PCT_W-1:0]    rsp_speed_percent,
   output logic [tsp_pkg::DUTY_W-1:0]          rsp_pwm_duty,
   output logic                                rsp_forward,
   output logic                                rsp_move_done
);

   localparam int SW = tsp_pkg::SPEED_W;
   localparam int PW = tsp_pkg::POS_W;

   // Move state
   logic                        awaiting_ff, awaiting_in;
   logic signed [PW-1:0]        enc_ff;
   logic signed [PW-1:0]        start_ff;
   logic [PW-1:0]               rul_ff, rul_in;
   logic [PW-1:0]               rdl_ff, rdl_in;
   logic signed [SW-1:0]        speed_ff, speed_in;
   logic signed [SW-1:0]        step_ff, step_in;
   tsp_pkg::zone_type           zone_ff, zone_in;

   // Staged and delivered result
   logic signed [tsp_pkg::PCT_W-1:0] pct_ff, pct_in;
   logic [tsp_pkg::DUTY_W-1:0]       duty_ff, duty_in;
   logic                             fwd_ff, done_ff;
   logic signed [tsp_pkg::PCT_W-1:0] out_pct_ff;
   logic [tsp_pkg::DUTY_W-1:0]       out_duty_ff;
   logic                             out_fwd_ff, out_done_ff;

   // Divider hookup
   logic signed [tsp_pkg::GAIN_W-1:0]  gain_up, gain_sel;
   logic [tsp_pkg::GAIN_W-1:0]         gain_mag;
   logic [PW-1:0]                      lim_sel;
   logic                               div_done;
   logic signed [SW-1:0]               div_q;

   // Speed arithmetic
   logic signed [SW-1:0]   max_ext;
   logic [SW-1:0]          abs_speed, abs_max;
   logic signed [SW-1:0]   up_base, creep;
   logic signed [SW-1:0]   up_next, dn_next;
   logic [PW:0]            limit_sum;
   logic signed [PW:0]     pos_diff, cruise_diff;
   logic [PW-1:0]          progress, cruise_end;
   logic signed [PW-1:0]   pct_raw;
   logic signed [PW-1:0]   pct_trunc;
   logic [tsp_pkg::MAG_W-1:0] pct_mag;
   logic [tsp_pkg::DUTY_W-1:0] duty_lut [tsp_pkg::PCT_MAX+1];

   function automatic logic signed [SW-1:0] sat_add(input logic signed [SW-1:0] a,
                                                    input logic signed [SW-1:0] b);
      logic signed [SW:0] sum;
      sum = {a[SW-1], a} + {b[SW-1], b};
      if (sum[SW] != sum[SW-1]) begin
         sat_add = sum[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
      end else begin
         sat_add = sum[SW-1:0];
      end
   endfunction

   // Duty table: full scale minus magnitude share, low bits kept
   for (genvar m = 0; m <= tsp_pkg::PCT_MAX; m++) begin : g_duty
      assign duty_lut[m] = tsp_pkg::DUTY_W'(DUTY_FULL_SCALE
                                            - (m * DUTY_FULL_SCALE) / tsp_pkg::PCT_MAX);
   end

   // Dividend is +/- max_speed times ten, divisor is the ramp limit plus one
   assign gain_up  = tsp_pkg::GAIN_W'(cfg.max_speed) * $signed(tsp_pkg::GAIN_W'(tsp_pkg::STEP_GAIN));
   assign gain_sel = cmd.div_down ? -gain_up : gain_up;
   assign gain_mag = gain_sel[tsp_pkg::GAIN_W-1] ? tsp_pkg::GAIN_W'(-gain_sel)
                                                 : tsp_pkg::GAIN_W'(gain_sel);
   assign lim_sel  = cmd.div_down ? rdl_ff : rul_ff;

   tsp_divider u_divider (
      .clock        (clock),
      .reset        (reset),
      .go           (cmd.div_go),
      .dividend_mag (gain_mag[tsp_pkg::DIV_BITS-1:0]),
      .negate       (gain_sel[tsp_pkg::GAIN_W-1]),
      .divisor      ({1'b0, lim_sel} + tsp_pkg::DIVISOR_W'(1)),
      .done         (div_done),
      .quotient     (div_q)
   );

   // Limits halve when the ramps overlap
   assign limit_sum = {1'b0, cfg.accel_distance} + {1'b0, cfg.decel_distance};
   always_comb begin
      if (limit_sum > {1'b0, cfg.total_distance}) begin
         rul_in = cfg.total_distance >> 1;
         rdl_in = cfg.total_distance >> 1;
      end else begin
         rul_in = cfg.accel_distance;
         rdl_in = cfg.decel_distance;
      end
   end

   // Distance travelled and end of cruise
   assign pos_diff    = {enc_ff[PW-1], enc_ff} - {start_ff[PW-1], start_ff};
   assign progress    = pos_diff[PW] ? PW'(-pos_diff) : PW'(pos_diff);
   assign cruise_diff = $signed({1'b0, cfg.total_distance}) - $signed({1'b0, rdl_ff});
   assign cruise_end  = cruise_diff[PW] ? PW'(-cruise_diff) : PW'(cruise_diff);

   always_comb begin
      priority if (progress < rul_ff) begin
         zone_in = tsp_pkg::ZONE_UP;
      end else if (progress < cruise_end) begin
         zone_in = tsp_pkg::ZONE_CRUISE;
      end else if (progress < cfg.total_distance) begin
         zone_in = tsp_pkg::ZONE_DECEL;
      end else begin
         zone_in = tsp_pkg::ZONE_DONE;
      end
   end

   // Percent from Q16.8, truncated toward zero, clamped
   assign pct_raw   = speed_ff[SW-1:8];
   assign pct_trunc = pct_raw + PW'(speed_ff[SW-1] && (speed_ff[7:0] != 8'd0));
   always_comb begin
      priority if (pct_trunc > $signed(PW'(tsp_pkg::PCT_MAX))) begin
         pct_in = tsp_pkg::PCT_W'(tsp_pkg::PCT_MAX);
      end else if (pct_trunc < -$signed(PW'(tsp_pkg::PCT_MAX))) begin
         pct_in = -$signed(tsp_pkg::PCT_W'(tsp_pkg::PCT_MAX));
      end else begin
         pct_in = pct_trunc[tsp_pkg::PCT_W-1:0];
      end
   end
   assign pct_mag = pct_in[tsp_pkg::PCT_W-1] ? tsp_pkg::MAG_W'(-pct_in)
                                             : tsp_pkg::MAG_W'(pct_in);
   assign duty_in = duty_lut[pct_mag];

   // Speed updates
   assign max_ext   = SW'(cfg.max_speed);
   assign abs_speed = speed_ff[SW-1] ? SW'(-speed_ff) : SW'(speed_ff);
   assign abs_max   = max_ext[SW-1] ? SW'(-max_ext) : SW'(max_ext);
   assign up_base   = (abs_speed > abs_max) ? max_ext : speed_ff;
   assign up_next   = sat_add(up_base, step_ff);
   assign dn_next   = sat_add(speed_ff, div_q);
   always_comb begin
      priority if (cfg.max_speed > 0) begin
         creep = SW'(tsp_pkg::CREEP_Q88);
      end else if (cfg.max_speed < 0) begin
         creep = -$signed(SW'(tsp_pkg::CREEP_Q88));
      end else begin
         creep = '0;
      end
   end

   always_comb begin
      speed_in    = speed_ff;
      step_in     = step_ff;
      awaiting_in = awaiting_ff;
      if (cmd.start_move) begin
         awaiting_in = 1'b0;
      end
      if (cmd.write_up) begin
         step_in  = div_q;
         speed_in = div_q;
      end
      if (cmd.apply) begin
         unique case (zone_ff)
            tsp_pkg::ZONE_UP:     speed_in = up_next;
            tsp_pkg::ZONE_CRUISE: speed_in = max_ext;
            tsp_pkg::ZONE_DONE:   awaiting_in = 1'b1;
            default:              speed_in = speed_ff;
         endcase
      end
      if (cmd.write_down) begin
         step_in  = div_q;
         speed_in = (abs_speed <= SW'(tsp_pkg::CREEP_Q88)) ? creep : dn_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         awaiting_ff <= 1'b1;
      end else begin
         awaiting_ff <= awaiting_in;
      end
      speed_ff <= speed_in;
      step_ff  <= step_in;
      if (cmd.latch_enc) begin
         enc_ff <= req_encoder_count;
      end
      if (cmd.start_move) begin
         start_ff <= enc_ff;
         rul_ff   <= rul_in;
         rdl_ff   <= rdl_in;
      end
      if (cmd.eval) begin
         zone_ff <= zone_in;
         pct_ff  <= pct_in;
         duty_ff <= duty_in;
         fwd_ff  <= ~pct_in[tsp_pkg::PCT_W-1];
         done_ff <= (zone_in == tsp_pkg::ZONE_DONE);
      end
      if (cmd.load_rsp) begin
         out_pct_ff  <= pct_ff;
         out_duty_ff <= duty_ff;
         out_fwd_ff  <= fwd_ff;
         out_done_ff <= done_ff;
      end
   end

   assign status.awaiting = awaiting_ff;
   assign status.div_done = div_done;
   assign status.zone     = zone_ff;

   assign rsp_speed_percent = out_pct_ff;
   assign rsp_pwm_duty      = out_duty_ff;
   assign rsp_forward       = out_fwd_ff;
   assign rsp_move_done     = out_done_ff;

endmodule

[src/tsp_controller.sv]
// Sequencer for one tick: accept, move start, divisions, zone update and
// result delivery. Depends on tsp_pkg.
`timescale 1ns / 1ps

module tsp_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  tsp_pkg::status_type  status,
   output tsp_pkg::cmd_type     cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_UP_GO,
      ST_UP_WAIT,
      ST_EVAL,
      ST_APPLY,
      ST_DN_WAIT,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   // Decode commands and next state
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.latch_enc = 1'b1;
               state_in      = ST_START;
            end
         end
         ST_START: begin
            if (status.awaiting) begin
               cmd.start_move = 1'b1;
               state_in       = ST_UP_GO;
            end else begin
               state_in = ST_EVAL;
            end
         end
         ST_UP_GO: begin
            cmd.div_go = 1'b1;
            state_in   = ST_UP_WAIT;
         end
         ST_UP_WAIT: begin
            if (status.div_done) begin
               cmd.write_up = 1'b1;
               state_in     = ST_EVAL;
            end
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            state_in = ST_APPLY;
         end
         ST_APPLY: begin
            if (status.zone == tsp_pkg::ZONE_DECEL) begin
               cmd.div_go   = 1'b1;
               cmd.div_down = 1'b1;
               state_in     = ST_DN_WAIT;
            end else begin
               cmd.apply = 1'b1;
               state_in  = ST_EMIT;
            end
         end
         ST_DN_WAIT: begin
            if (status.div_done) begin
               cmd.write_down = 1'b1;
               state_in       = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Hold the result until taken, set it when a new one loads
   always_comb begin
      priority if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

[src/trapezoid_speed_profile.sv]
// Top level of the trapezoid speed profile: register port, controller and
// datapath. Depends on tsp_pkg, tsp_controller and tsp_datapath.
`timescale 1ns / 1ps

// One request per encoder tick produces one response with the speed held
// before that tick, its PWM duty, the direction and a done flag. A tick
// in the ramp-up and cruise zones runs from accept through the states
// START, EVAL, APPLY and EMIT to the response; the first tick of a move
// adds the ramp-up step division and every ramp-down tick adds the
// ramp-down step division. Both divisions share one radix-2 divider that
// resolves one quotient bit per cycle over 19 bits. The next request is
// taken while the previous response still waits at the output register.
// Registers (32-bit APB, byte address 4*i): total_distance, accel_distance,
// decel_distance, max_speed (Q8.8 percent, signed); write them only while
// the block is idle.

module trapezoid_speed_profile #(
   parameter int DUTY_FULL_SCALE = 1023
) (
   input  logic                                clock,
   input  logic                                reset,
   // Request channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [tsp_pkg::POS_W-1:0]    req_encoder_count,
   // Response channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [tsp_pkg::PCT_W-1:0]    rsp_speed_percent,
   output logic [tsp_pkg::DUTY_W-1:0]          rsp_pwm_duty,
   output logic                                rsp_forward,
   output logic                                rsp_move_done,
   // Register port
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [tsp_pkg::ADDR_W-1:0]          paddr,
   input  logic [tsp_pkg::DATA_W-1:0]          pwdata,
   output logic [tsp_pkg::DATA_W-1:0]          prdata,
   output logic                                pready
);

   tsp_pkg::cfg_type    cfg_ff, cfg_in;
   tsp_pkg::cmd_type    cmd;
   tsp_pkg::status_type status;
   tsp_pkg::reg_index_type reg_sel;
   logic                wr_en;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_sel = tsp_pkg::reg_index_type'(paddr[3:2]);

   // Write the addressed register
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_sel)
            tsp_pkg::REG_TOTAL: cfg_in.total_distance = pwdata[tsp_pkg::POS_W-1:0];
            tsp_pkg::REG_ACCEL: cfg_in.accel_distance = pwdata[tsp_pkg::POS_W-1:0];
            tsp_pkg::REG_DECEL: cfg_in.decel_distance = pwdata[tsp_pkg::POS_W-1:0];
            tsp_pkg::REG_MAX:   cfg_in.max_speed      = pwdata[tsp_pkg::POS_W-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read back the addressed register
   always_comb begin
      unique case (reg_sel)
         tsp_pkg::REG_TOTAL: prdata = tsp_pkg::DATA_W'(cfg_ff.total_distance);
         tsp_pkg::REG_ACCEL: prdata = tsp_pkg::DATA_W'(cfg_ff.accel_distance);
         tsp_pkg::REG_DECEL: prdata = tsp_pkg::DATA_W'(cfg_ff.decel_distance);
         tsp_pkg::REG_MAX:   prdata = tsp_pkg::DATA_W'(cfg_ff.max_speed);
         default:            prdata = '0;
      endcase
   end

   tsp_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   tsp_datapath #(
      .DUTY_FULL_SCALE (DUTY_FULL_SCALE)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .cfg               (cfg_ff),
      .req_encoder_count (req_encoder_count),
      .rsp_speed_percent (rsp_speed_percent),
      .rsp_pwm_duty      (rsp_pwm_duty),
      .rsp_forward       (rsp_forward),
      .rsp_move_done     (rsp_move_done)
   );

endmodule

[src/tsp_checker.sv]
// Port-level checks for the trapezoid speed profile, bound to the top level.
// Depends on trapezoid_speed_profile port names only.
`timescale 1ns / 1ps

module tsp_checker #(
   parameter int DUTY_FULL_SCALE = 1023
) (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic signed [7:0] rsp_speed_percent,
   input logic [9:0]        rsp_pwm_duty,
   input logic              rsp_forward,
   input logic              rsp_move_done
);

   localparam logic [9:0] DUTY_IDLE = 10'(DUTY_FULL_SCALE);

   // Hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_speed_percent)
         && $stable(rsp_pwm_duty) && $stable(rsp_forward) && $stable(rsp_move_done))
      else $error("response changed while stalled");

   // Drop ready after a request is taken, while the controller works on the tick
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken in back-to-back cycles");

   // Clamp speed to the percent range
   a_pct_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_speed_percent <= 8'sd100) && (rsp_speed_percent >= -8'sd100))
      else $error("speed percent out of range");

   // Direction follows the sign of the speed
   a_forward_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_forward == !rsp_speed_percent[7]))
      else $error("direction does not match speed sign");

   // Zero speed gives full-scale (off) duty
   a_duty_stop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_speed_percent == 8'sd0) |-> (rsp_pwm_duty == DUTY_IDLE))
      else $error("duty not at full scale for zero speed");

endmodule

bind trapezoid_speed_profile tsp_checker #(
   .DUTY_FULL_SCALE (DUTY_FULL_SCALE)
) u_tsp_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_speed_percent (rsp_speed_percent),
   .rsp_pwm_duty      (rsp_pwm_duty),
   .rsp_forward       (rsp_forward),
   .rsp_move_done     (rsp_move_done)
);

[dv/trapezoid_speed_profile_test.sv]
// Self-checking testbench for trapezoid_speed_profile: APB register setup,
// directed and random encoder ticks, scoreboard against an in-bench profile predictor.
// Depends on tsp_pkg and the trapezoid_speed_profile RTL.
`timescale 1ns / 1ps

module trapezoid_speed_profile_test;
   import tsp_pkg::*;

   localparam int DUTY_FS      = 1023;
   localparam int RANDOM_ITEMS = 1000;
   localparam int SPEED_TOP    = 8388607;
   localparam int SPEED_BOTTOM = -8388608;

   typedef struct packed {
      logic signed [PCT_W-1:0] speed_percent;
      logic [DUTY_W-1:0]       pwm_duty;
      logic                    forward;
      logic                    move_done;
   } tick_result_t;

   // One row of the directed table; cfg fields apply only when set_cfg is high
   typedef struct packed {
      logic                    set_cfg;
      logic [POS_W-1:0]        tot;
      logic [POS_W-1:0]        acc;
      logic [POS_W-1:0]        dec;
      logic signed [POS_W-1:0] maxs;
      logic signed [POS_W-1:0] enc;
      logic                    typed;
      tick_result_t            want;
   } tick_row_t;

   localparam tick_result_t IDLE_DONE = '{speed_percent: 8'sd0, pwm_duty: 10'd1023,
                                          forward: 1'b1, move_done: 1'b1};
   localparam tick_result_t FULL_FWD = '{speed_percent: 8'sd100, pwm_duty: 10'd0,
                                         forward: 1'b1, move_done: 1'b0};
   localparam tick_result_t FULL_FWD_DONE = '{speed_percent: 8'sd100, pwm_duty: 10'd0,
                                              forward: 1'b1, move_done: 1'b1};
   localparam tick_result_t FULL_REV = '{speed_percent: -8'sd100, pwm_duty: 10'd0,
                                         forward: 1'b0, move_done: 1'b0};
   localparam tick_result_t FULL_REV_DONE = '{speed_percent: -8'sd100, pwm_duty: 10'd0,
                                              forward: 1'b0, move_done: 1'b1};

   localparam int DIRECTED_ROWS = 23;

   tick_row_t directed_rows [DIRECTED_ROWS] = '{
      // zero config after reset: every tick starts and ends a move at once
      '{1'b0, 16'd0, 16'd0, 16'd0, 16'sd0, 16'sd0, 1'b1, IDLE_DONE},
      '{1'b0, 16'd0, 16'd0, 16'd0, 16'sd0, 16'sh8000, 1'b1, IDLE_DONE},
      '{1'b0, 16'd0, 16'd0, 16'd0, 16'sd0, 16'sd32767, 1'b1, IDLE_DONE},
      // full forward speed over the whole encoder span
      '{1'b1, 16'd65535, 16'd0, 16'd0, 16'sd25600, 16'sh8000, 1'b1, FULL_FWD},
      '{1'b0, 16'd0, 16'd0, 16'd0, 16'sd0, 16'sd32767, 1'b1, FULL_FWD_DONE},
      // full reverse speed
      '{1'b1, 16'd65535, 16'd0, 16'd0, -16'sd25600, 16'sh8000, 1'b1, FULL_REV},
      '{1'b0, 16'd0, 16'd0, 16'd0, 16'sd0, 16'sd0, 1'b0, '0},
      '{1'b0, 16'd0, 16'd0, 16'd0, 16'sd0, 16'sd32767, 1'b1, FULL_REV_DONE},
      // ramps longer than an odd total: both limits halved
      '{1'b1, 16'd7, 16'd5, 16'd5, 16'sd2560, 16'sd100, 1'b0, '0},
      '{1'b0, 16'd0, 16'd0, 16'd0, 16'sd0, 16'sd101, 1'b0, '0},
      '{1'b0, 16'd0, 16'd0, 16'd0, 16'sd0, 16'sd103, 1'b0, '0},
      '{1'b0, 16'd0, 16'd0, 16'd0, 16'sd0, 16'sd104, 1'b0, '0},
      '{1'b0, 16'd0, 16'd0, 16'd0, 16'sd0, 16'sd107, 1'b0, '0},
      // zero max speed: creep floor collapses to zero
      '{1'b1, 16'd6, 16'd1, 16'd2, 16'sd0, 16'sd0, 1'b0, '0},
      '{1'b0, 16'd0, 16'd0, 16'd0, 16'sd0, 16'sd1, 1'b0, '0},
      '{1'b0, 16'd0, 16'd0, 16'd0, 16'sd0, 16'sd4, 1'b0, '0},
      '{1'b0, 16'd0, 16'd0, 16'd0, 16'sd0, 16'sd5, 1'b0, '0},
      '{1'b0, 16'd0, 16'd0, 16'd0, 16'sd0, 16'sd6, 1'b0, '0},
      // negative inexact step: divisions truncate toward zero
      '{1'b1, 16'd10, 16'd6, 16'd3, -16'sd300, 16'sd0, 1'b0, '0},
      '{1'b0, 16'd0, 16'd0, 16'd0, 16'sd0, -16'sd2, 1'b0, '0},
      '{1'b0, 16'd0, 16'd0, 16'd0, 16'sd0, -16'sd6, 1'b0, '0},
      '{1'b0, 16'd0, 16'd0, 16'd0, 16'sd0, -16'sd8, 1'b0, '0},
      '{1'b0, 16'd0, 16'd0, 16'd0, 16'sd0, -16'sd10, 1'b0, '0}
   };

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   logic signed [POS_W-1:0]  req_encoder_count;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic signed [PCT_W-1:0]  rsp_speed_percent;
   logic [DUTY_W-1:0]        rsp_pwm_duty;
   logic                     rsp_forward;
   logic                     rsp_move_done;
   logic                     psel;
   logic                     penable;
   logic                     pwrite;
   logic [ADDR_W-1:0]        paddr;
   logic [DATA_W-1:0]        pwdata;
   logic [DATA_W-1:0]        prdata;
   logic                     pready;

   // Predictor state: live config plus the latched move state
   cfg_type                  prof_cfg = '0;
   logic                     prof_awaiting = 1'b1;
   logic signed [SPEED_W-1:0] prof_speed = '0;
   logic signed [SPEED_W-1:0] prof_step = '0;
   logic signed [POS_W-1:0]  prof_start = '0;
   logic [POS_W-1:0]         prof_up_lim = '0;
   logic [POS_W-1:0]         prof_dn_lim = '0;

   tick_result_t             pending_ticks [$];
   tick_result_t             typed_value = '0;
   logic                     typed_pending = 1'b0;
   int                       error_count = 0;
   int                       items_sent = 0;
   logic                     no_idle = 1'b0;
   logic                     stall_request = 1'b0;
   int                       hold_left = 0;

   trapezoid_speed_profile #(
      .DUTY_FULL_SCALE(DUTY_FS)
   ) i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_encoder_count (req_encoder_count),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_speed_percent (rsp_speed_percent),
      .rsp_pwm_duty      (rsp_pwm_duty),
      .rsp_forward       (rsp_forward),
      .rsp_move_done     (rsp_move_done),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Clamp a speed sum to the 24-bit Q16.8 range
   function automatic logic signed [SPEED_W-1:0] clamp_speed(input longint v);
      if (v > SPEED_TOP) return SPEED_W'(SPEED_TOP);
      if (v < SPEED_BOTTOM) return SPEED_W'(SPEED_BOTTOM);
      return SPEED_W'(v);
   endfunction

   // Advance the profile by one tick and return the response it produces
   function automatic tick_result_t advance_profile(input logic signed [POS_W-1:0] enc);
      tick_result_t r;
      int tot, maxs, spd, pct, mag, progress, cruise_end, max_mag, spd_mag;
      tot  = int'(prof_cfg.total_distance);
      maxs = int'(prof_cfg.max_speed);
      // latch start position, limits and ramp-up step on the first tick of a move
      if (prof_awaiting) begin
         prof_up_lim = prof_cfg.accel_distance;
         prof_dn_lim = prof_cfg.decel_distance;
         if (int'(prof_cfg.accel_distance) + int'(prof_cfg.decel_distance) > tot) begin
            prof_up_lim = prof_cfg.total_distance >> 1;
            prof_dn_lim = prof_cfg.total_distance >> 1;
         end
         prof_start    = enc;
         prof_step     = SPEED_W'((maxs * STEP_GAIN) / (int'(prof_up_lim) + 1));
         prof_speed    = prof_step;
         prof_awaiting = 1'b0;
      end
      // report the speed held before this tick's update
      spd = int'(prof_speed);
      pct = spd / 256;
      if (pct > PCT_MAX) pct = PCT_MAX;
      if (pct < -PCT_MAX) pct = -PCT_MAX;
      mag = (pct < 0) ? -pct : pct;
      r.speed_percent = PCT_W'(pct);
      r.pwm_duty      = DUTY_W'(DUTY_FS - (mag * DUTY_FS) / PCT_MAX);
      r.forward       = (pct >= 0);
      r.move_done     = 1'b0;
      progress   = int'(enc) - int'(prof_start);
      progress   = (progress < 0) ? -progress : progress;
      cruise_end = tot - int'(prof_dn_lim);
      cruise_end = (cruise_end < 0) ? -cruise_end : cruise_end;
      max_mag    = (maxs < 0) ? -maxs : maxs;
      spd_mag    = (spd < 0) ? -spd : spd;
      // ramp up, cruise, ramp down toward creep, or finish
      if (progress < int'(prof_up_lim)) begin
         if (spd_mag > max_mag) spd = maxs;
         prof_speed = clamp_speed(longint'(spd) + longint'(prof_step));
      end else if (progress < cruise_end) begin
         prof_speed = SPEED_W'(maxs);
      end else if (progress < tot) begin
         prof_step = SPEED_W'((-maxs * STEP_GAIN) / (int'(prof_dn_lim) + 1));
         if (spd_mag <= CREEP_Q88) begin
            if (maxs > 0) prof_speed = SPEED_W'(CREEP_Q88);
            else if (maxs < 0) prof_speed = SPEED_W'(-CREEP_Q88);
            else prof_speed = '0;
         end else begin
            prof_speed = clamp_speed(longint'(spd) + longint'(prof_step));
         end
      end else begin
         prof_awaiting = 1'b1;
         r.move_done   = 1'b1;
      end
      return r;
   endfunction

   task automatic flag_error(input string msg);
      error_count++;
      if (error_count <= 10) $display("ERROR at %0t: %s", $realtime, msg);
   endtask

   // Predict on every accepted request, check every accepted response
   always @(posedge clock) begin
      tick_result_t pred, want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            pred = advance_profile(req_encoder_count);
            pending_ticks.push_back(typed_pending ? typed_value : pred);
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_ticks.size() == 0) begin
               flag_error("response with no request outstanding");
            end else begin
               want = pending_ticks.pop_front();
               if (rsp_speed_percent !== want.speed_percent)
                  flag_error($sformatf("speed_percent expected %0d got %0d",
                                       want.speed_percent, rsp_speed_percent));
               if (rsp_pwm_duty !== want.pwm_duty)
                  flag_error($sformatf("pwm_duty expected %0d got %0d",
                                       want.pwm_duty, rsp_pwm_duty));
               if (rsp_forward !== want.forward)
                  flag_error($sformatf("forward expected %0b got %0b",
                                       want.forward, rsp_forward));
               if (rsp_move_done !== want.move_done)
                  flag_error($sformatf("move_done expected %0b got %0b",
                                       want.move_done, rsp_move_done));
            end
         end
      end
   end

   // Response side: random back-pressure, long hold-off on request
   always @(negedge clock) begin
      if (stall_request) begin
         hold_left     = 400;
         stall_request = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (no_idle) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= 38);
      end
   end

   // Offer one request, with random gaps first; returns on the falling edge
   task automatic send_tick(input logic signed [POS_W-1:0] enc);
      while (!no_idle && $urandom_range(99) < 38) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_encoder_count <= enc;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      @(negedge clock);
   endtask

   // Drop valid and wait until every outstanding response has arrived
   task automatic wait_drained;
      req_valid <= 1'b0;
      while (pending_ticks.size() != 0) @(negedge clock);
   endtask

   // APB write followed by a read-back of the same register
   task automatic write_reg(input reg_index_type idx, input logic [POS_W-1:0] value);
      logic [DATA_W-1:0] wdata;
      wdata        = $urandom();
      wdata[POS_W-1:0] = value;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ADDR_W'(4 * int'(idx));
      pwdata  <= wdata;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      case (idx)
         REG_TOTAL: prof_cfg.total_distance = value;
         REG_ACCEL: prof_cfg.accel_distance = value;
         REG_DECEL: prof_cfg.decel_distance = value;
         REG_MAX:   prof_cfg.max_speed      = value;
         default: ;
      endcase
      @(negedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata[POS_W-1:0] !== value)
         flag_error($sformatf("register %s read %0h expected %0h",
                              idx.name(), prdata[POS_W-1:0], value));
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic load_profile(input int tot, input int acc, input int dec, input int maxs);
      write_reg(REG_TOTAL, POS_W'(tot));
      write_reg(REG_ACCEL, POS_W'(acc));
      write_reg(REG_DECEL, POS_W'(dec));
      write_reg(REG_MAX, POS_W'(maxs));
   endtask

   // Close a move left open by noise: jump to the far end of the encoder range
   task automatic finish_move;
      int s, far;
      if (!prof_awaiting) begin
         s   = int'(prof_start);
         far = (s >= 0) ? s + 32768 : 32767 - s;
         if (int'(prof_cfg.total_distance) > far) write_reg(REG_TOTAL, POS_W'(far));
         send_tick((s >= 0) ? 16'sh8000 : 16'sd32767);
      end
   endtask

   // One well-formed move: start, random strides toward the total, done tick
   task automatic run_move;
      int tot, pos, s, stride, k;
      bit up, dwell;
      tot   = int'(prof_cfg.total_distance);
      up    = $urandom_range(1);
      s     = int'($urandom_range(0, 65535 - tot)) - 32768 + (up ? 0 : tot);
      dwell = (tot > 1) && ($urandom_range(9) == 0);
      pos   = 0;
      send_tick(POS_W'(s));
      while (pos < tot) begin
         stride = $urandom_range(0, tot / 10 + 1);
         pos    = (pos + stride > tot) ? tot : pos + stride;
         // park just short of the end so the ramp-down runs into saturation
         if (dwell && pos >= tot - 1) begin
            for (k = 0; k < 100; k++) send_tick(POS_W'(up ? s + tot - 1 : s - tot + 1));
            dwell = 1'b0;
         end
         send_tick(POS_W'(up ? s + pos : s - pos));
      end
   endtask

   initial begin
      int tot, acc, dec, maxs, phase, k, drain;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_encoder_count = '0;
      psel              = 1'b0;
      penable           = 1'b0;
      pwrite            = 1'b0;
      paddr             = '0;
      pwdata            = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed table
      for (k = 0; k < DIRECTED_ROWS; k++) begin
         if (directed_rows[k].set_cfg) begin
            wait_drained;
            load_profile(int'(directed_rows[k].tot), int'(directed_rows[k].acc),
                         int'(directed_rows[k].dec), int'(directed_rows[k].maxs));
         end
         typed_pending = directed_rows[k].typed;
         typed_value   = directed_rows[k].want;
         send_tick(directed_rows[k].enc);
      end
      typed_pending = 1'b0;

      // Random phases: new config, close any open move, moves, then noise
      phase = 0;
      while (items_sent < DIRECTED_ROWS + RANDOM_ITEMS) begin
         wait_drained;
         @(posedge clock);
         no_idle       = (phase >= 10 && phase < 14);
         stall_request = (phase == 3 || phase == 17);
         @(negedge clock);
         case ($urandom_range(9))
            0:       tot = 0;
            1:       tot = 65535;
            2:       tot = $urandom_range(1, 65535);
            default: tot = $urandom_range(1, 60);
         endcase
         case ($urandom_range(5))
            0:       acc = 0;
            1:       acc = 65535;
            default: acc = $urandom_range(0, tot);
         endcase
         case ($urandom_range(5))
            0:       dec = 0;
            1:       dec = 65535;
            default: dec = $urandom_range(0, tot);
         endcase
         case ($urandom_range(5))
            0:       maxs = 25600;
            1:       maxs = -25600;
            2:       maxs = 0;
            default: maxs = int'($urandom_range(0, 51200)) - 25600;
         endcase
         load_profile(tot, acc, dec, maxs);
         finish_move;
         repeat ($urandom_range(1, 3)) run_move;
         repeat ($urandom_range(0, 4)) send_tick(POS_W'($urandom()));
         phase++;
      end

      // Drain, then allow the block's worst-case latency for stray responses
      req_valid <= 1'b0;
      drain = 0;
      while (pending_ticks.size() != 0 && drain < 20000) begin
         @(negedge clock);
         drain++;
      end
      repeat (60) @(negedge clock);
      if (pending_ticks.size() != 0)
         flag_error($sformatf("%0d responses never arrived", pending_ticks.size()));
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Hard stop if the run hangs
   initial begin
      #20_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

[trapezoid_speed_profile.f]
src/tsp_pkg.sv
src/tsp_divider.sv
src/tsp_datapath.sv
src/tsp_controller.sv
src/trapezoid_speed_profile.sv
src/tsp_checker.sv
dv/trapezoid_speed_profile_test.sv
